### hdl/uttf_pkg.sv
`default_nettype none

package uttf_pkg;

    localparam int SECS_W  = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int FAT_W   = 32;

    // reciprocal multipliers, each exact over the operand range used
    localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // x / 675, shift 35
    localparam logic [12:0] HOUR_RECIP  = 13'd4661;      // x / 225, shift 20
    localparam logic [10:0] MIN_RECIP   = 11'd1093;      // x / 15,  shift 14
    localparam logic [14:0] Y1460_RECIP = 15'd22983;     // x / 365, shift 23
    localparam logic [17:0] YEAR_RECIP  = 18'd183860;    // x / 365, shift 26
    localparam logic [10:0] MP_RECIP    = 11'd1714;      // x / 153, shift 18

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [19:0] DAY_SHIFT     = 20'd719468;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [11:0] ERA5_YEAR     = 12'd2000;
    localparam logic [11:0] ERA4_YEAR     = 12'd1600;
    localparam logic [11:0] FAT_BASE_YEAR = 12'd1980;
    localparam logic [31:0] FAT_FALLBACK  = 32'h5421_0000;

    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        begin
            case (mp)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd61;
                4'd3:    r = 9'd92;
                4'd4:    r = 9'd122;
                4'd5:    r = 9'd153;
                4'd6:    r = 9'd184;
                4'd7:    r = 9'd214;
                4'd8:    r = 9'd245;
                4'd9:    r = 9'd275;
                4'd10:   r = 9'd306;
                4'd11:   r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/uttf_if.sv
`default_nettype none

interface uttf_in_if;
    logic                        valid;
    logic                        ready;
    logic [uttf_pkg::SECS_W-1:0] epoch_secs;

    modport source (output valid, output epoch_secs, input ready);
    modport sink   (input valid, input epoch_secs, output ready);
endinterface

interface uttf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         civil_valid;
    logic [uttf_pkg::YEAR_W-1:0]  year;
    logic [uttf_pkg::MONTH_W-1:0] month;
    logic [uttf_pkg::DAY_W-1:0]   day_of_month;
    logic [uttf_pkg::HOUR_W-1:0]  hour;
    logic [uttf_pkg::MIN_W-1:0]   minute;
    logic [uttf_pkg::SEC_W-1:0]   second;
    logic [uttf_pkg::FAT_W-1:0]   fat_time;

    modport source (output valid, output civil_valid, output year, output month,
                    output day_of_month, output hour, output minute, output second,
                    output fat_time, input ready);
    modport sink   (input valid, input civil_valid, input year, input month,
                    input day_of_month, input hour, input minute, input second,
                    input fat_time, output ready);
endinterface

`default_nettype wire

### hdl/unix_time_to_fat_timestamp.sv
// channel    dir   payload
// secs_ch    in    epoch_secs
// date_ch    out   civil_valid, year, month, day_of_month, hour, minute, second, fat_time
//
// nine register stages, one request per cycle sustained while date_ch does not stall
// each stage holds about one constant multiply with an add or compare
// rst_n clears the stage valid bits only, data registers are not reset
// a stall on date_ch freezes the whole pipe, secs_ch.ready follows it

`default_nettype none

module unix_time_to_fat_timestamp (
    input  wire             clk,
    input  wire             rst_n,
    uttf_in_if.sink         secs_ch,
    uttf_out_if.source      date_ch
);

    localparam int NUM_ST = 8;

    typedef struct packed {
        logic        zero;
        logic [31:0] secs;
        logic [50:0] p_day;
        logic [15:0] days;
        logic [16:0] sod;
        logic [19:0] z;
        logic [25:0] p_hr;
        logic        era5;
        logic [17:0] doe;
        logic [4:0]  hour;
        logic [11:0] rem;
        logic [30:0] p_a;
        logic [2:0]  b;
        logic        c;
        logic [20:0] p_min;
        logic [17:0] n;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [35:0] p_yoe;
        logic [8:0]  yoe;
        logic [8:0]  doy;
        logic [21:0] p_mp;
    } pipe_t;

    typedef struct packed {
        logic        civil_valid;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] fat_time;
    } out_t;

    pipe_t             st_reg  [NUM_ST];
    pipe_t             st_next [NUM_ST];
    logic [NUM_ST-1:0] vld_reg;
    logic              out_vld_reg;
    out_t              out_reg;
    out_t              out_next;
    logic              adv;

    assign adv           = !out_vld_reg || date_ch.ready;
    assign secs_ch.ready = adv;

    // split into days and seconds of day
    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].secs  = secs_ch.epoch_secs;
        st_next[0].zero  = (secs_ch.epoch_secs == 32'd0);
        st_next[0].p_day = 51'(secs_ch.epoch_secs[31:7]) * 51'(uttf_pkg::DAY_RECIP);
    end

    always_comb
    begin
        logic [31:0] day_secs;
        st_next[1]      = st_reg[0];
        st_next[1].days = st_reg[0].p_day[50:35];
        day_secs        = 32'(st_reg[0].p_day[50:35]) * uttf_pkg::SECS_PER_DAY;
        st_next[1].sod  = 17'(st_reg[0].secs - day_secs);
        st_next[1].z    = 20'(st_reg[0].p_day[50:35]) + uttf_pkg::DAY_SHIFT;
    end

    // era and day of era
    always_comb
    begin
        st_next[2]      = st_reg[1];
        st_next[2].p_hr = 26'(st_reg[1].sod[16:4]) * 26'(uttf_pkg::HOUR_RECIP);
        st_next[2].era5 = (st_reg[1].z >= uttf_pkg::ERA5_START);
        st_next[2].doe  = 18'(st_reg[1].z - ((st_reg[1].z >= uttf_pkg::ERA5_START) ?
                          uttf_pkg::ERA5_START : uttf_pkg::ERA4_START));
    end

    always_comb
    begin
        logic [4:0] hr;
        hr              = st_reg[2].p_hr[24:20];
        st_next[3]      = st_reg[2];
        st_next[3].hour = hr;
        st_next[3].rem  = 12'(st_reg[2].sod - 17'(hr) * 17'd3600);
        st_next[3].p_a  = 31'(st_reg[2].doe[17:2]) * 31'(uttf_pkg::Y1460_RECIP);
        st_next[3].b    = 3'(st_reg[2].doe >= 18'd36524) + 3'(st_reg[2].doe >= 18'd73048)
                        + 3'(st_reg[2].doe >= 18'd109572) + 3'(st_reg[2].doe >= 18'd146096);
        st_next[3].c    = (st_reg[2].doe == 18'd146096);
    end

    always_comb
    begin
        st_next[4]       = st_reg[3];
        st_next[4].p_min = 21'(st_reg[3].rem[11:2]) * 21'(uttf_pkg::MIN_RECIP);
        st_next[4].n     = st_reg[3].doe - 18'(st_reg[3].p_a[30:23])
                         + 18'(st_reg[3].b) - 18'(st_reg[3].c);
    end

    always_comb
    begin
        logic [5:0] mi;
        mi                = st_reg[4].p_min[19:14];
        st_next[5]        = st_reg[4];
        st_next[5].minute = mi;
        st_next[5].second = 6'(st_reg[4].rem - 12'(mi) * 12'd60);
        st_next[5].p_yoe  = 36'(st_reg[4].n) * 36'(uttf_pkg::YEAR_RECIP);
    end

    // year of era and day of march-based year
    always_comb
    begin
        logic [8:0]  y;
        logic [17:0] ydays;
        logic [1:0]  yc;
        y               = st_reg[5].p_yoe[34:26];
        yc              = 2'(y >= 9'd100) + 2'(y >= 9'd200) + 2'(y >= 9'd300);
        ydays           = 18'(y) * 18'd365 + 18'(y[8:2]) - 18'(yc);
        st_next[6]      = st_reg[5];
        st_next[6].yoe  = y;
        st_next[6].doy  = 9'(st_reg[5].doe - ydays);
    end

    always_comb
    begin
        st_next[7]      = st_reg[6];
        st_next[7].p_mp = (22'(st_reg[6].doy) * 22'd5 + 22'd2) * 22'(uttf_pkg::MP_RECIP);
    end

    // month, day, year and fat packing
    always_comb
    begin
        logic [3:0]  mp;
        logic [3:0]  mo;
        logic [4:0]  d;
        logic [11:0] y;
        logic [6:0]  yf;
        mp = st_reg[7].p_mp[21:18];
        mo = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        d  = 5'(st_reg[7].doy - uttf_pkg::month_start(mp) + 9'd1);
        y  = (st_reg[7].era5 ? uttf_pkg::ERA5_YEAR : uttf_pkg::ERA4_YEAR)
           + 12'(st_reg[7].yoe) + 12'(mo <= 4'd2);
        yf = (y < uttf_pkg::FAT_BASE_YEAR) ? 7'd0 : 7'(y - uttf_pkg::FAT_BASE_YEAR);
        if (st_reg[7].zero)
        begin
            out_next          = '0;
            out_next.fat_time = uttf_pkg::FAT_FALLBACK;
        end
        else
        begin
            out_next.civil_valid  = 1'b1;
            out_next.year         = y;
            out_next.month        = mo;
            out_next.day_of_month = d;
            out_next.hour         = st_reg[7].hour;
            out_next.minute       = st_reg[7].minute;
            out_next.second       = st_reg[7].second;
            out_next.fat_time     = {yf, mo, d, st_reg[7].hour, st_reg[7].minute,
                                     st_reg[7].second[5:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NUM_ST-2:0], secs_ch.valid};
            out_vld_reg <= vld_reg[NUM_ST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_ST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            out_reg <= out_next;
        end
    end

    assign date_ch.valid        = out_vld_reg;
    assign date_ch.civil_valid  = out_reg.civil_valid;
    assign date_ch.year         = out_reg.year;
    assign date_ch.month        = out_reg.month;
    assign date_ch.day_of_month = out_reg.day_of_month;
    assign date_ch.hour         = out_reg.hour;
    assign date_ch.minute       = out_reg.minute;
    assign date_ch.second       = out_reg.second;
    assign date_ch.fat_time     = out_reg.fat_time;

endmodule

`default_nettype wire
